// File: hdl/cbal_pkg.sv
// Package for the cubic Bezier arc length unit: payload types, widths,
// register indexes and limits. No dependencies.
package cbal_pkg;

  // Samples per segment. Must be a power of two so that the division of each
  // Bernstein sum by STEPS cubed reduces to a shift.
  localparam int unsigned CBAL_STEPS = 64;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned SMP_W     = 20;
  localparam int unsigned SEG_W     = 20;
  localparam int unsigned TOTAL_W   = 28;
  localparam int unsigned ROOT_W    = 21;
  localparam int unsigned RAD_W     = 2 * ROOT_W;
  localparam int unsigned REM_W     = ROOT_W + 2;
  localparam int unsigned DIST_W    = 22;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [SEG_W-1:0]   SEG_MAX   = 20'hFFFFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 28'hFFFFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_START_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] ctrl1_x;
    logic signed [COORD_W-1:0] ctrl1_y;
    logic signed [COORD_W-1:0] ctrl2_x;
    logic signed [COORD_W-1:0] ctrl2_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      last_segment;
  } in_item_t;

  typedef struct packed {
    logic [SEG_W-1:0]   segment_length;
    logic [TOTAL_W-1:0] path_total;
    logic               path_done;
  } out_item_t;

  // Offset-binary view of a signed coordinate.
  function automatic logic [COORD_W-1:0] to_offset(input logic [COORD_W-1:0] v);
    return v ^ {1'b1, {(COORD_W-1){1'b0}}};
  endfunction

endpackage

// File: hdl/cubic_bezier_arc_length_unit.sv
// Top level of the cubic Bezier arc length unit: sequencer and shared datapath.
// Depends on cbal_pkg.
//
// Usage: the path start point is written through the cfg port (index 0 is
// start_x, index 1 is start_y) while the unit is idle. Each input
// transaction on the in channel carries one cubic segment; the segment start
// is the current point. The unit samples the curve at STEPS points, sums the
// chord lengths and returns one out transaction with the segment length, the
// running path total (saturating) and path_done, a copy of last_segment.
// A last segment resets the total to zero and the current point to the
// configured start.
// Structure: one multiplier and one square root step are reused under a small
// sequencer. STEPS is a power of two, so the division by STEPS cubed is a
// shift. Each sample computes the Bernstein weights, then the x and y sums
// and their rounding shifts, the squares, the square root and the chord
// accumulation. The unit takes one segment at a time: in_stall_o is high
// after a segment is taken until the unit returns to idle with its result
// handed to the output register. The result sits in an output
// register; if the receiver stalls, a finished next item waits in its
// final state until the register frees. Reset clears the start point, the
// current point and the total to zero and empties the output register.
module cubic_bezier_arc_length_unit #(
  parameter int unsigned STEPS = cbal_pkg::CBAL_STEPS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cbal_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cbal_pkg::COORD_W-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cbal_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cbal_pkg::out_item_t                 out_data_o
);
  import cbal_pkg::*;

  localparam int unsigned N3     = STEPS * STEPS * STEPS;
  localparam int unsigned N3_W   = $clog2(N3 + 1);
  localparam int unsigned LOG_N3 = 3 * $clog2(STEPS);
  localparam int unsigned IDX_W  = $clog2(STEPS + 1);
  localparam int unsigned SQI_W  = 2 * IDX_W;
  localparam int unsigned MA_W   = (N3_W > SMP_W) ? N3_W : SMP_W;
  localparam int unsigned PR_W   = MA_W + SMP_W;
  localparam int unsigned ACC_W  = N3_W + COORD_W;
  localparam int unsigned DIV_W  = N3_W + SMP_W;
  localparam int unsigned SUM_W  = DIST_W + IDX_W;
  localparam int unsigned SEGX_W = SUM_W + 1 - 4;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WGT  = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_SQR  = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;
  localparam logic [2:0] S_ACC  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  // Control and path state.
  logic [2:0]         state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               coord_q;
  logic [IDX_W-1:0]   idx_q;
  logic               mid_q;
  logic               out_valid_q;
  logic [COORD_W-1:0] start_x_q, start_y_q, cur_x_q, cur_y_q;
  logic [TOTAL_W-1:0] total_q;

  // Datapath registers.
  in_item_t           item_q;
  logic [SQI_W-1:0]   uu_q, ii_q;
  logic [N3_W-1:0]    w_q [4];
  logic [ACC_W-1:0]   acc_q;
  logic [SMP_W-1:0]   sx_q, sy_q, px_q, py_q;
  logic [RAD_W-1:0]   rad_q;
  logic [REM_W-1:0]   rrem_q;
  logic [ROOT_W-1:0]  root_q;
  logic [SUM_W-1:0]   sum_q;
  out_item_t          out_q;

  // Combinational signals.
  logic [IDX_W-1:0]   u_w;
  logic [MA_W-1:0]    mul_a;
  logic [SMP_W-1:0]   mul_b;
  logic [PR_W-1:0]    prod;
  logic [N3_W-1:0]    prod_lo, prod_x3;
  logic [COORD_W-1:0] pt;
  logic [SMP_W-1:0]   dx, dy;
  logic [ACC_W-1:0]   acc_nxt;
  logic [DIV_W-1:0]   dval;
  logic [SMP_W-1:0]   quo;
  logic [REM_W+1:0]   rtry, rtrial;
  logic               rbit;
  logic [DIST_W-1:0]  chord_len;
  logic [SUM_W:0]     sum8;
  logic [SEGX_W-1:0]  segx;
  logic [SEG_W-1:0]   seg;
  logic [TOTAL_W:0]   tsum;
  logic [TOTAL_W-1:0] tot;
  logic               in_acc, out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign u_w = IDX_W'(STEPS) - idx_q;
  assign dx  = (sx_q >= px_q) ? (sx_q - px_q) : (px_q - sx_q);
  assign dy  = (sy_q >= py_q) ? (sy_q - py_q) : (py_q - sy_q);

  // Control point for the current Bernstein term and coordinate.
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    pt = coord_q ? to_offset(cur_y_q) : to_offset(cur_x_q);
      2'd1:    pt = coord_q ? to_offset(item_q.ctrl1_y) : to_offset(item_q.ctrl1_x);
      2'd2:    pt = coord_q ? to_offset(item_q.ctrl2_y) : to_offset(item_q.ctrl2_x);
      default: pt = coord_q ? to_offset(item_q.end_y) : to_offset(item_q.end_x);
    endcase
  end

  // The one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_WGT: begin
        case (cnt_q)
          5'd0: begin mul_a = MA_W'(u_w);  mul_b = SMP_W'(u_w);  end
          5'd1: begin mul_a = MA_W'(uu_q); mul_b = SMP_W'(u_w);  end
          5'd2: begin mul_a = MA_W'(uu_q); mul_b = SMP_W'(idx_q); end
          5'd3: begin mul_a = MA_W'(idx_q); mul_b = SMP_W'(idx_q); end
          5'd4: begin mul_a = MA_W'(ii_q); mul_b = SMP_W'(u_w);  end
          5'd5: begin mul_a = MA_W'(ii_q); mul_b = SMP_W'(idx_q); end
          default: ;
        endcase
      end
      S_MAC: begin
        mul_a = MA_W'(w_q[cnt_q[1:0]]);
        mul_b = SMP_W'(pt);
      end
      S_SQR: begin
        mul_a = cnt_q[0] ? MA_W'(dy) : MA_W'(dx);
        mul_b = cnt_q[0] ? dy : dx;
      end
      default: ;
    endcase
  end

  assign prod    = PR_W'(mul_a) * PR_W'(mul_b);
  assign prod_lo = prod[N3_W-1:0];
  assign prod_x3 = prod_lo + (prod_lo << 1);
  assign acc_nxt = ((cnt_q == '0) ? '0 : acc_q) + prod[ACC_W-1:0];
  assign dval    = {acc_q, 4'b0000} + DIV_W'(N3 / 2);

  // STEPS cubed is a power of two, so the rounded division is a shift.
  assign quo = SMP_W'(dval >> LOG_N3);

  // Square root step, two radicand bits at a time.
  assign rtry      = {rrem_q, rad_q[RAD_W-1 -: 2]};
  assign rtrial    = {2'b00, root_q, 2'b01};
  assign rbit      = (rtry >= rtrial);
  assign chord_len = DIST_W'(root_q) + DIST_W'(rrem_q > REM_W'(root_q));

  // Rounding from Q.4 to whole units and saturation.
  assign sum8 = {1'b0, sum_q} + (SUM_W + 1)'(8);
  assign segx = sum8[SUM_W:4];
  assign seg  = (segx > SEGX_W'(SEG_MAX)) ? SEG_MAX : segx[SEG_W-1:0];
  assign tsum = {1'b0, total_q} + (TOTAL_W + 1)'(seg);
  assign tot  = tsum[TOTAL_W] ? TOTAL_MAX : tsum[TOTAL_W-1:0];

  // Sequencer and path state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      coord_q     <= 1'b0;
      idx_q       <= '0;
      mid_q       <= 1'b0;
      out_valid_q <= 1'b0;
      start_x_q   <= '0;
      start_y_q   <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      total_q     <= '0;
    end else begin
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_X: begin
            start_x_q <= cfg_data_i;
            if (!mid_q) cur_x_q <= cfg_data_i;
          end
          REG_START_Y: begin
            start_y_q <= cfg_data_i;
            if (!mid_q) cur_y_q <= cfg_data_i;
          end
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_WGT;
            cnt_q   <= '0;
            coord_q <= 1'b0;
            idx_q   <= IDX_W'(1);
          end
        end
        S_WGT: begin
          if (cnt_q == CNT_W'(5)) begin
            state_q <= S_MAC;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_MAC: begin
          if (cnt_q == CNT_W'(4)) begin
            cnt_q   <= '0;
            coord_q <= !coord_q;
            state_q <= coord_q ? S_SQR : S_MAC;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SQR: begin
          if (cnt_q[0]) begin
            state_q <= S_ROOT;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_ROOT: begin
          if (cnt_q == CNT_W'(ROOT_W - 1)) begin
            state_q <= S_ACC;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_ACC: begin
          if (idx_q == IDX_W'(STEPS)) begin
            state_q <= S_FIN;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_WGT;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
            if (item_q.last_segment) begin
              total_q <= '0;
              cur_x_q <= start_x_q;
              cur_y_q <= start_y_q;
              mid_q   <= 1'b0;
            end else begin
              total_q <= tot;
              cur_x_q <= item_q.end_x;
              cur_y_q <= item_q.end_y;
              mid_q   <= 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          item_q <= in_data_i;
          sum_q  <= '0;
          px_q   <= {to_offset(cur_x_q), 4'b0000};
          py_q   <= {to_offset(cur_y_q), 4'b0000};
        end
      end
      S_WGT: begin
        case (cnt_q)
          5'd0:    uu_q   <= prod[SQI_W-1:0];
          5'd1:    w_q[0] <= prod_lo;
          5'd2:    w_q[1] <= prod_x3;
          5'd3:    ii_q   <= prod[SQI_W-1:0];
          5'd4:    w_q[2] <= prod_x3;
          5'd5:    w_q[3] <= prod_lo;
          default: ;
        endcase
      end
      S_MAC: begin
        if (cnt_q == CNT_W'(4)) begin
          if (coord_q) sy_q <= quo;
          else         sx_q <= quo;
        end else begin
          acc_q <= acc_nxt;
        end
      end
      S_SQR: begin
        if (cnt_q[0]) begin
          rad_q  <= RAD_W'(rad_q) + RAD_W'(prod[2*SMP_W-1:0]);
          rrem_q <= '0;
          root_q <= '0;
        end else begin
          rad_q <= RAD_W'(prod[2*SMP_W-1:0]);
        end
      end
      S_ROOT: begin
        rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
        rrem_q <= rbit ? REM_W'(rtry - rtrial) : rtry[REM_W-1:0];
        root_q <= {root_q[ROOT_W-2:0], rbit};
      end
      S_ACC: begin
        sum_q <= sum_q + SUM_W'(chord_len);
        px_q  <= sx_q;
        py_q  <= sy_q;
      end
      S_FIN: begin
        if (out_free) begin
          out_q.segment_length <= seg;
          out_q.path_total     <= tot;
          out_q.path_done      <= item_q.last_segment;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/cbal_checker.sv
// Port-level checker for the cubic Bezier arc length unit, with its bind.
// Depends on cbal_pkg and cubic_bezier_arc_length_unit.
module cbal_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input cbal_pkg::out_item_t out_data_o
);
  import cbal_pkg::*;

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The unit is busy right after it takes a segment.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("unit not busy after accepting a segment");

  // A result never appears in the cycle after a segment is taken.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // The running total always covers the segment that it includes.
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.path_total >= TOTAL_W'(out_data_o.segment_length))
    else $error("path total below segment length");

endmodule

bind cubic_bezier_arc_length_unit cbal_checker u_cbal_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
